@@ rtl/core/ksc_pkg.sv @@
// Shared constants, types and helpers for the keyword substitution cipher.
// Has no dependencies; the cipher top level imports it.
package ksc_pkg;

    localparam int unsigned ALPHA_SIZE = 95;
    localparam int unsigned BLK_W      = 8;
    localparam int unsigned NUM_BLK    = 12;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 64;

    localparam logic [7:0] CHAR_FIRST = 8'd32;
    localparam logic [7:0] CHAR_LAST  = 8'd126;

    // Register indexes, taken from paddr[4:3] (registers sit 8 bytes apart).
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_MODE     = 2'd2;

    typedef logic [6:0]       t_pos;
    typedef logic [3:0]       t_blk;
    typedef logic [2:0]       t_bit;
    typedef logic [BLK_W-1:0] t_blk_bits;

    function automatic logic [3:0] popcount8(input t_blk_bits v);
        logic [3:0] acc;
        acc = 4'd0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + {3'd0, v[i]};
        end
        return acc;
    endfunction

endpackage

@@ rtl/core/keyword_substitution_cipher.sv @@
// Keyword substitution cipher over printable ASCII, as a four stage pipeline.
// Depends on ksc_pkg for constants, types and the popcount helper.
//
// Usage: the key set (95 bits over characters 32..126) and the mode are
// written over the APB port; registers sit at byte addresses 0, 8 and 16.
// Text items enter on i_in_valid / o_in_stall, results leave on
// o_out_valid / i_out_stall. An item is taken when valid is high and stall
// is low. Each accepted item gives exactly one result, which passes through
// the stage registers r1 to r4 in order and is then shown on the outputs.
// The block sustains one item per cycle while no stall holds it, because every
// stage advances whenever the stage after it moves. Bytes outside 32..126 come back
// unchanged with o_passed_through set.
// Per-block counts of the key set are kept in registers that follow the
// configuration; after reset and after any register write the input stalls
// while r_hold counts down and those counts settle. Input also stalls while psel
// is high. When the receiver stalls, results hold in place and the stages
// behind fill up before the input stalls; nothing is lost or repeated.
// Reset (synchronous, active low) clears the key set and mode to zero and
// empties the pipeline.
module keyword_substitution_cipher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ksc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ksc_pkg::DATA_W-1:0]  pwdata,
    output logic [ksc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_in_char,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_out_char,
    output logic                        o_passed_through
);
    import ksc_pkg::*;

    // Configuration registers
    logic [63:0] r_key_low;
    logic [30:0] r_key_high;
    logic        r_decrypt;
    logic [1:0]  r_hold;
    logic        w_wr;

    // Key set derived counts
    logic [95:0] w_set96, w_abs96;
    t_blk_bits   w_sblk [NUM_BLK];
    t_blk_bits   w_ablk [NUM_BLK];
    logic [3:0]  r_bcnt [NUM_BLK];
    logic [4:0]  n_gpre [NUM_BLK];
    logic [4:0]  r_gpre [NUM_BLK];
    logic [5:0]  n_gtot [3];
    logic [5:0]  r_gtot [3];
    t_pos        r_pre_pres [NUM_BLK];
    t_pos        r_pre_abs  [NUM_BLK];
    t_pos        r_abs_total;
    t_pos        w_goff [3];

    // Pipeline
    logic        w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_accept;
    logic        r1_v, r2_v, r3_v, r4_v;
    logic [7:0]  r1_char, r2_char, r3_char;
    logic        r1_pass, r2_pass, r3_pass;
    t_pos        r1_p, r2_p;
    logic        r2_sel_abs, r3_sel_abs;
    t_pos        r2_k;
    logic        r2_present;
    t_bit        r2_lp;
    t_blk        r3_blk;
    t_bit        r3_rem;
    t_pos        r3_j;
    logic [7:0]  r4_char;
    logic        r4_pass;

    logic        n2_sel_abs, n2_present;
    t_pos        n2_k;
    t_bit        n2_lp;
    t_blk        n3_blk;
    t_bit        n3_rem;
    t_pos        n3_j;
    logic [7:0]  n4_char;
    t_blk        w2_b, w3_b;
    t_bit        w2_bit, w3_bit, w4_pos;
    t_blk_bits   w2_blk, w4_blk;
    logic [3:0]  w2_cnt, w4_cnt;
    t_pos        w3_prev, w3_pp, w3_pa;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_decrypt  <= 1'b0;
            r_hold     <= 2'd3;
        end else begin
            if (w_wr) begin
                case (paddr[4:3])
                    REG_KEY_LOW:  r_key_low  <= pwdata;
                    REG_KEY_HIGH: r_key_high <= pwdata[30:0];
                    REG_MODE:     r_decrypt  <= pwdata[0];
                    default: ;
                endcase
                r_hold <= 2'd3;
            end else if (r_hold != 2'd0) begin
                r_hold <= r_hold - 2'd1;
            end
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_KEY_LOW:  prdata = r_key_low;
            REG_KEY_HIGH: prdata = {33'd0, r_key_high};
            REG_MODE:     prdata = {63'd0, r_decrypt};
            default:      prdata = '0;
        endcase
    end

    // ---------------- key set counts ----------------
    // Bit 95 pads the last block and belongs to neither set.
    assign w_set96 = {1'b0, r_key_high, r_key_low};
    assign w_abs96 = {1'b0, ~r_key_high, ~r_key_low};

    always_comb begin
        for (int b = 0; b < NUM_BLK; b++) begin
            w_sblk[b] = w_set96[b*BLK_W +: BLK_W];
            w_ablk[b] = w_abs96[b*BLK_W +: BLK_W];
        end
    end

    // Prefix counts within groups of four blocks, then group offsets.
    always_comb begin
        for (int g = 0; g < 3; g++) begin
            n_gtot[g] = 6'd0;
            for (int t = 0; t < 4; t++) begin
                n_gpre[4*g+t] = n_gtot[g][4:0];
                n_gtot[g]     = n_gtot[g] + {2'd0, r_bcnt[4*g+t]};
            end
        end
        w_goff[0] = 7'd0;
        w_goff[1] = {1'b0, r_gtot[0]};
        w_goff[2] = {1'b0, r_gtot[0]} + {1'b0, r_gtot[1]};
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NUM_BLK; b++) begin
            r_bcnt[b]     <= popcount8(w_sblk[b]);
            r_gpre[b]     <= n_gpre[b];
            r_pre_pres[b] <= {2'd0, r_gpre[b]} + w_goff[b/4];
            r_pre_abs[b]  <= 7'(b*BLK_W) - ({2'd0, r_gpre[b]} + w_goff[b/4]);
        end
        for (int g = 0; g < 3; g++) begin
            r_gtot[g] <= n_gtot[g];
        end
        r_abs_total <= 7'(ALPHA_SIZE) - (w_goff[2] + {1'b0, r_gtot[2]});
    end

    // ---------------- handshake ----------------
    assign w_rdy4     = !r4_v || !i_out_stall;
    assign w_rdy3     = !r3_v || w_rdy4;
    assign w_rdy2     = !r2_v || w_rdy3;
    assign w_rdy1     = !r1_v || w_rdy2;
    assign o_in_stall = !w_rdy1 || (r_hold != 2'd0) || psel;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= w_accept;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
        end
    end

    // ---------------- stage 2: rank target and local counts ----------------
    always_comb begin
        // Encrypt: the first entries hold absent characters, highest first.
        if (r1_p < r_abs_total) begin
            n2_sel_abs = 1'b1;
            n2_k       = r_abs_total - 7'd1 - r1_p;
        end else begin
            n2_sel_abs = 1'b0;
            n2_k       = r1_p - r_abs_total;
        end
        w2_b   = r1_p[6:3];
        w2_bit = r1_p[2:0];
        w2_blk = (w2_b < t_blk'(NUM_BLK)) ? w_sblk[w2_b] : '0;
        w2_cnt = popcount8(w2_blk & ((8'd1 << w2_bit) - 8'd1));
        n2_lp      = w2_cnt[2:0];
        n2_present = w2_blk[w2_bit];
    end

    // ---------------- stage 3: block search / decrypt position ----------------
    always_comb begin
        n3_blk = '0;
        for (int t = 1; t < NUM_BLK; t++) begin
            if ((r2_sel_abs ? r_pre_abs[t] : r_pre_pres[t]) <= r2_k) begin
                n3_blk = t_blk'(t);
            end
        end
        w3_prev = (n3_blk < t_blk'(NUM_BLK))
                ? (r2_sel_abs ? r_pre_abs[n3_blk] : r_pre_pres[n3_blk]) : '0;
        n3_rem  = 3'(r2_k - w3_prev);

        w3_b   = r2_p[6:3];
        w3_bit = r2_p[2:0];
        w3_pp  = (w3_b < t_blk'(NUM_BLK)) ? r_pre_pres[w3_b] : '0;
        w3_pa  = (w3_b < t_blk'(NUM_BLK)) ? r_pre_abs[w3_b]  : '0;
        if (r2_present) begin
            n3_j = r_abs_total + w3_pp + {4'd0, r2_lp};
        end else begin
            n3_j = r_abs_total - 7'd1 - (w3_pa + {4'd0, w3_bit - r2_lp});
        end
    end

    // ---------------- stage 4: bit select within the block ----------------
    always_comb begin
        if (r3_blk < t_blk'(NUM_BLK)) begin
            w4_blk = r3_sel_abs ? w_ablk[r3_blk] : w_sblk[r3_blk];
        end else begin
            w4_blk = '0;
        end
        w4_cnt = 4'd0;
        w4_pos = 3'd0;
        for (int t = 0; t < BLK_W; t++) begin
            if (w4_blk[t] && (w4_cnt == {1'b0, r3_rem})) begin
                w4_pos = 3'(t);
            end
            w4_cnt = w4_cnt + {3'd0, w4_blk[t]};
        end
        if (r3_pass) begin
            n4_char = r3_char;
        end else if (r_decrypt) begin
            n4_char = CHAR_FIRST + {1'b0, r3_j};
        end else begin
            n4_char = CHAR_FIRST + {1'b0, r3_blk, w4_pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && w_accept) begin
            r1_char <= i_in_char;
            r1_pass <= (i_in_char < CHAR_FIRST) || (i_in_char > CHAR_LAST);
            r1_p    <= 7'(i_in_char - CHAR_FIRST);
        end
        if (w_rdy2) begin
            r2_char    <= r1_char;
            r2_pass    <= r1_pass;
            r2_p       <= r1_p;
            r2_sel_abs <= n2_sel_abs;
            r2_k       <= n2_k;
            r2_present <= n2_present;
            r2_lp      <= n2_lp;
        end
        if (w_rdy3) begin
            r3_char    <= r2_char;
            r3_pass    <= r2_pass;
            r3_sel_abs <= r2_sel_abs;
            r3_blk     <= n3_blk;
            r3_rem     <= n3_rem;
            r3_j       <= n3_j;
        end
        if (w_rdy4) begin
            r4_char <= n4_char;
            r4_pass <= r3_pass;
        end
    end

    assign o_out_valid      = r4_v;
    assign o_out_char       = r4_char;
    assign o_passed_through = r4_pass;

    // ---------------- assertions ----------------
    a_no_take_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> !w_accept)
        else $error("item taken right after a register write");

    a_printable_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_passed_through) |->
        (o_out_char >= CHAR_FIRST) && (o_out_char <= CHAR_LAST))
        else $error("substituted byte outside the printable range");

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && r2_v && r3_v && r4_v && i_out_stall) |-> o_in_stall)
        else $error("input not stalled with a full pipeline");

    a_drain_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !r4_v) |=> r4_v)
        else $error("item lost between stage three and the output");

endmodule
